/* hdl/lef_pkg.sv */
// Package: shared widths, register indexes, reset values and the centroid table.
`default_nettype none

package lef_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int SENS_W   = 5;
  localparam int GYRO_W   = 16;
  localparam int LINE_W   = 11;
  localparam int FUSED_W  = 11;
  localparam int BASE_W   = 6;
  localparam int LIMIT_W  = 10;
  localparam int CGAIN_W  = 6;
  localparam int GGAIN_W  = 16;
  localparam int Q16_W    = 17;
  localparam int INTEG_W  = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam int MUL_AW = 32;
  localparam int MUL_BW = 18;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic [Q16_W-1:0] Q16_ONE = 17'h10000;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 10'd50;
  localparam logic [CGAIN_W-1:0] CGAIN_RST = 6'd27;
  localparam logic [GGAIN_W-1:0] GGAIN_RST = 16'd2294;
  localparam logic [Q16_W-1:0]   ALPHA_RST = 17'd60293;
  localparam logic [Q16_W-1:0]   KEEP_RST  = 17'd39322;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ERROR_LIMIT     = 3'd0,
    CFG_CORNER_GAIN     = 3'd1,
    CFG_GYRO_GAIN       = 3'd2,
    CFG_FUSION_ALPHA    = 3'd3,
    CFG_INTEGRATOR_KEEP = 3'd4
  } cfg_reg_t;

  // weighted centroid in tenths, truncated toward zero
  function automatic logic signed [BASE_W-1:0] line_base(input logic [SENS_W-1:0] bits);
    logic signed [BASE_W-1:0] v;
    case (bits)
      5'd1:    v = -6'sd28;
      5'd2:    v = -6'sd13;
      5'd3:    v = -6'sd20;
      5'd5:    v = -6'sd14;
      5'd6:    v = -6'sd6;
      5'd7:    v = -6'sd13;
      5'd8:    v = 6'sd13;
      5'd9:    v = -6'sd7;
      5'd11:   v = -6'sd9;
      5'd12:   v = 6'sd6;
      5'd13:   v = -6'sd5;
      5'd15:   v = -6'sd7;
      5'd16:   v = 6'sd28;
      5'd18:   v = 6'sd7;
      5'd19:   v = -6'sd4;
      5'd20:   v = 6'sd14;
      5'd22:   v = 6'sd5;
      5'd23:   v = -6'sd3;
      5'd24:   v = 6'sd20;
      5'd25:   v = 6'sd4;
      5'd26:   v = 6'sd9;
      5'd28:   v = 6'sd13;
      5'd29:   v = 6'sd3;
      5'd30:   v = 6'sd7;
      default: v = 6'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hdl/lef_if.sv */
// Interfaces: sensor input channel and fused result channel.
`default_nettype none

interface lef_in_if import lef_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [SENS_W-1:0]        sensor_bits;
  logic signed [GYRO_W-1:0] gyro_rate;

  modport source (output valid, output sensor_bits, output gyro_rate, input ready);
  modport sink   (input valid, input sensor_bits, input gyro_rate, output ready);
endinterface

interface lef_out_if import lef_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [LINE_W-1:0]  line_error;
  logic signed [FUSED_W-1:0] fused_error;
  logic                      corner_seen;

  modport source (output valid, output line_error, output fused_error,
                  output corner_seen, input ready);
  modport sink   (input valid, input line_error, input fused_error,
                  input corner_seen, output ready);
endinterface

`default_nettype wire

/* hdl/lef_mul.sv */
// Shared signed multiplier with registered product.
`default_nettype none

module lef_mul import lef_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [MUL_AW-1:0] a,
  input  wire logic signed [MUL_BW-1:0] b,
  output logic signed [MUL_PW-1:0]      p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

`default_nettype wire

/* hdl/line_error_gyro_fusion_core.sv */
// Top level: line centroid and gyro integrator fusion on one shared multiplier.
//
//  channel   dir  signals                                        transfer
//  in_ch     in   sensor_bits[4:0], gyro_rate[15:0]              valid & ready
//  out_ch    out  line_error[10:0], fused_error[10:0], corner    valid & ready
//  cfg       in   cfg_we, cfg_addr[2:0], cfg_wdata[16:0]         cfg_we
//
// An item holds the sequencer, transfer to next transfer, through the corner, gyro and
// integrate states, then mix and fuse when the line is seen or plain when only the
// integrator is output. Every product runs through the single 32x18 multiplier. Ready is
// high only while the sequencer is idle. A finished result waits in the output register
// while a new item is taken; that item then holds in its last state until the register
// frees. Synchronous active-low reset clears state, integrator, valid; presets config.
`default_nettype none

module line_error_gyro_fusion_core import lef_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lef_in_if.sink                     in_ch,
  lef_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SH  = FRAC_BITS - 20;
  localparam int LSH = (SH > 0) ? SH : 0;
  localparam int RSH = (SH < 0) ? -SH : 0;
  localparam int GW  = MUL_PW + LSH + 1;
  localparam int AW  = (FRAC_BITS + 30 > MUL_PW) ? FRAC_BITS + 31 : MUL_PW + 1;
  localparam logic signed [AW-1:0] BBIAS = (AW'(1) <<< (FRAC_BITS + 16)) - AW'(1);
  localparam logic signed [AW-1:0] PBIAS = (AW'(1) <<< FRAC_BITS) - AW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_CORNER, S_GYRO, S_INTEG, S_PLAIN,
    S_MIXK, S_MIXL, S_MIXS, S_MIXW,
    S_FUSI, S_FUSL, S_FUSS, S_FUSO
  } state_t;

  // configuration
  logic [LIMIT_W-1:0] lim_r;
  logic [CGAIN_W-1:0] cgain_r;
  logic [GGAIN_W-1:0] ggain_r;
  logic [Q16_W-1:0]   alpha_r;
  logic [Q16_W-1:0]   keep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r   <= LIMIT_RST;
      cgain_r <= CGAIN_RST;
      ggain_r <= GGAIN_RST;
      alpha_r <= ALPHA_RST;
      keep_r  <= KEEP_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_ERROR_LIMIT:     lim_r   <= cfg_wdata[LIMIT_W-1:0];
        CFG_CORNER_GAIN:     cgain_r <= cfg_wdata[CGAIN_W-1:0];
        CFG_GYRO_GAIN:       ggain_r <= cfg_wdata[GGAIN_W-1:0];
        CFG_FUSION_ALPHA:    alpha_r <= cfg_wdata[Q16_W-1:0];
        CFG_INTEGRATOR_KEEP: keep_r  <= cfg_wdata[Q16_W-1:0];
        default: ;
      endcase
    end
  end

  logic [Q16_W-1:0] alpha_eff;
  logic [Q16_W-1:0] keep_eff;
  assign alpha_eff = (alpha_r > Q16_ONE) ? Q16_ONE : alpha_r;
  assign keep_eff  = (keep_r > Q16_ONE) ? Q16_ONE : keep_r;

  // datapath registers
  state_t                       state_r, state_nxt;
  logic signed [LINE_W-1:0]     line_r, line_nxt;
  logic                         corner_r, corner_nxt;
  logic                         mid_r, mid_nxt;
  logic signed [GYRO_W-1:0]     gyro_r, gyro_nxt;
  logic signed [AW-1:0]         acc_r, acc_nxt;
  logic signed [INTEG_W-1:0]    integ_r, integ_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic signed [LINE_W-1:0]     out_line_r;
  logic signed [FUSED_W-1:0]    out_fused_r;
  logic                         out_corner_r;

  logic                         in_xfer;
  logic                         done;
  logic                         can_out;
  logic [SENS_W-1:0]            bits;
  logic signed [MUL_AW-1:0]     mul_a;
  logic [Q16_W-1:0]             mul_bu;
  logic signed [MUL_PW-1:0]     prod_r;
  logic signed [GW-1:0]         gsum;
  logic [GW-INTEG_W:0]          gtop;
  logic signed [AW-1:0]         mshift;
  logic [AW-INTEG_W:0]          mtop;
  logic signed [AW-1:0]         braw;
  logic signed [AW-1:0]         praw;
  logic signed [AW-1:0]         raw;
  logic signed [AW-1:0]         lim_s;
  logic signed [AW-1:0]         clamped;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign bits        = in_ch.sensor_bits;
  assign done        = (state_r == S_FUSO) || (state_r == S_PLAIN);
  assign can_out     = !out_valid_r || out_ch.ready;

  // operand select for the shared multiplier
  always_comb begin
    mul_a  = '0;
    mul_bu = '0;
    case (state_r)
      S_CORNER: begin
        mul_a  = MUL_AW'(line_r);
        mul_bu = Q16_W'(cgain_r);
      end
      S_GYRO: begin
        mul_a  = MUL_AW'(gyro_r);
        mul_bu = Q16_W'(ggain_r);
      end
      S_MIXK: begin
        mul_a  = integ_r;
        mul_bu = keep_eff;
      end
      S_MIXL: begin
        mul_a  = MUL_AW'(line_r);
        mul_bu = Q16_ONE - keep_eff;
      end
      S_FUSI: begin
        mul_a  = integ_r;
        mul_bu = Q16_ONE - alpha_eff;
      end
      S_FUSL: begin
        mul_a  = MUL_AW'(line_r);
        mul_bu = alpha_eff;
      end
      default: ;
    endcase
  end

  lef_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   ($signed({1'b0, mul_bu})),
    .p_r (prod_r)
  );

  // gyro step, rescaled from Q20 with floor, then saturating add
  assign gsum   = GW'(integ_r) + ((GW'(prod_r) <<< LSH) >>> RSH);
  assign gtop   = gsum[GW-1:INTEG_W-1];
  assign mshift = acc_r >>> 16;
  assign mtop   = mshift[AW-1:INTEG_W-1];

  // truncation toward zero of both output paths, then clamp
  assign braw    = (acc_r + (acc_r[AW-1] ? BBIAS : AW'(0))) >>> (FRAC_BITS + 16);
  assign praw    = (AW'(integ_r) + (integ_r[INTEG_W-1] ? PBIAS : AW'(0))) >>> FRAC_BITS;
  assign raw     = (state_r == S_FUSO) ? braw : praw;
  assign lim_s   = $signed(AW'(lim_r));
  assign clamped = (raw > lim_s) ? lim_s : ((raw < -lim_s) ? -lim_s : raw);

  always_comb begin
    state_nxt  = state_r;
    line_nxt   = line_r;
    corner_nxt = corner_r;
    mid_nxt    = mid_r;
    gyro_nxt   = gyro_r;
    acc_nxt    = acc_r;
    integ_nxt  = integ_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          line_nxt   = LINE_W'(line_base(bits));
          corner_nxt = (!bits[4] && bits[2] && bits[1] && bits[0]) ||
                       (!bits[0] && bits[2] && bits[3] && bits[4]);
          mid_nxt    = bits[2];
          gyro_nxt   = in_ch.gyro_rate;
          state_nxt  = S_CORNER;
        end
      end
      S_CORNER: state_nxt = S_GYRO;
      S_GYRO: begin
        if (corner_r) begin
          line_nxt = prod_r[LINE_W-1:0];
        end
        state_nxt = S_INTEG;
      end
      S_INTEG: begin
        if ((&gtop) || !(|gtop)) begin
          integ_nxt = gsum[INTEG_W-1:0];
        end else begin
          integ_nxt = gsum[GW-1] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
        end
        state_nxt = ((line_r != '0) || mid_r) ? S_MIXK : S_PLAIN;
      end
      S_MIXK: state_nxt = S_MIXL;
      S_MIXL: begin
        acc_nxt   = AW'(prod_r);
        state_nxt = S_MIXS;
      end
      S_MIXS: begin
        acc_nxt   = acc_r + (AW'(prod_r) <<< FRAC_BITS);
        state_nxt = S_MIXW;
      end
      S_MIXW: begin
        if ((&mtop) || !(|mtop)) begin
          integ_nxt = mshift[INTEG_W-1:0];
        end else begin
          integ_nxt = mshift[AW-1] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
        end
        state_nxt = S_FUSI;
      end
      S_FUSI: state_nxt = S_FUSL;
      S_FUSL: begin
        acc_nxt   = AW'(prod_r);
        state_nxt = S_FUSS;
      end
      S_FUSS: begin
        acc_nxt   = acc_r + (AW'(prod_r) <<< FRAC_BITS);
        state_nxt = S_FUSO;
      end
      S_FUSO, S_PLAIN: begin
        if (can_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (done && can_out) ? 1'b1 : (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_r   <= line_nxt;
    corner_r <= corner_nxt;
    mid_r    <= mid_nxt;
    gyro_r   <= gyro_nxt;
    acc_r    <= acc_nxt;
    if (done && can_out) begin
      out_line_r   <= line_r;
      out_fused_r  <= clamped[FUSED_W-1:0];
      out_corner_r <= corner_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.line_error  = out_line_r;
  assign out_ch.fused_error = out_fused_r;
  assign out_ch.corner_seen = out_corner_r;

  // checks
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input taken while an item is in progress");

  a_fused_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (($signed(out_ch.fused_error) <= $signed({1'b0, lim_r})) &&
                      ($signed(out_ch.fused_error) >= -$signed({1'b0, lim_r}))))
    else $error("fused error outside limit");

  a_plain_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.corner_seen) |->
      (($signed(out_ch.line_error) <= 11'sd28) && ($signed(out_ch.line_error) >= -11'sd28)))
    else $error("line error out of range without corner");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Testbench for line_error_gyro_fusion_core: directed and random ticks checked against a predictor.
`timescale 1ns / 1ps

module testbench;
  import lef_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int GYRO_SHIFT = 20 - FRAC_BITS_DEF;
  localparam int SENSOR_WEIGHT [SENS_W] = '{-28, -13, 0, 13, 28};
  localparam logic [SENS_W-1:0] LEFT_CORNER  = 5'b00111;
  localparam logic [SENS_W-1:0] RIGHT_CORNER = 5'b11100;

  typedef struct packed {
    logic signed [LINE_W-1:0]  line_error;
    logic signed [FUSED_W-1:0] fused_error;
    logic                      corner_seen;
  } error_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lef_in_if  in_ch ();
  lef_out_if out_ch ();

  line_error_gyro_fusion_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // register copies and integrator of the predictor
  int unsigned lim_cfg   = 32'(LIMIT_RST);
  int unsigned cgain_cfg = 32'(CGAIN_RST);
  int unsigned ggain_cfg = 32'(GGAIN_RST);
  int unsigned alpha_cfg = 32'(ALPHA_RST);
  int unsigned keep_cfg  = 32'(KEEP_RST);
  longint integ_q = 0;

  error_rec_t expected_errors[$];
  int errors = 0;
  int unsigned cycles = 0;
  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  logic sink_hold = 1'b0;
  event hold_go;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !sink_hold && !(sink_gaps && $urandom_range(99) < 12);
    end
  end

  always begin
    @(hold_go);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    error_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_errors.size() == 0) begin
        $error("unexpected result transfer: line_error %0d fused_error %0d",
               out_ch.line_error, out_ch.fused_error);
        errors++;
      end else begin
        want = expected_errors.pop_front();
        if (out_ch.line_error !== want.line_error) begin
          $error("line_error: expected %0d, got %0d", want.line_error, out_ch.line_error);
          errors++;
        end
        if (out_ch.fused_error !== want.fused_error) begin
          $error("fused_error: expected %0d, got %0d", want.fused_error, out_ch.fused_error);
          errors++;
        end
        if (out_ch.corner_seen !== want.corner_seen) begin
          $error("corner_seen: expected %0d, got %0d", want.corner_seen, out_ch.corner_seen);
          errors++;
        end
      end
    end
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint trunc_shift(input longint v, input int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  // one control tick: centroid, corner gain, gyro integration, blend and clamp
  task automatic fuse_tick(input logic [SENS_W-1:0] bits, input logic signed [GYRO_W-1:0] rate);
    int wsum;
    int nlit;
    int line;
    logic corner;
    longint step;
    longint lq;
    longint mix;
    longint fused;
    longint a;
    longint k;
    longint lim;
    error_rec_t rec;
    wsum = 0;
    nlit = 0;
    line = 0;
    for (int b = 0; b < SENS_W; b++) begin
      if (bits[b]) begin
        wsum += SENSOR_WEIGHT[b];
        nlit++;
      end
    end
    if (nlit != 0) line = wsum / nlit;
    corner = (!bits[4] && bits[2] && bits[1] && bits[0]) ||
             (!bits[0] && bits[2] && bits[3] && bits[4]);
    if (corner) line = line * int'(cgain_cfg);

    step = longint'(rate) * longint'(ggain_cfg);
    step = step >>> GYRO_SHIFT;
    integ_q = sat32(integ_q + step);

    a = (alpha_cfg > 65536) ? 64'sd65536 : longint'(alpha_cfg);
    k = (keep_cfg > 65536) ? 64'sd65536 : longint'(keep_cfg);
    lq = longint'(line) <<< FRAC_BITS_DEF;
    if (line != 0 || bits[2]) begin
      mix = integ_q * k + lq * (64'sd65536 - k);
      integ_q = sat32(mix >>> 16);
      fused = trunc_shift((64'sd65536 - a) * integ_q + a * lq, FRAC_BITS_DEF + 16);
    end else begin
      fused = trunc_shift(integ_q, FRAC_BITS_DEF);
    end
    lim = longint'(lim_cfg);
    if (fused > lim) fused = lim;
    if (fused < -lim) fused = -lim;

    rec.line_error = LINE_W'(line);
    rec.fused_error = FUSED_W'(fused);
    rec.corner_seen = corner;
    expected_errors.push_back(rec);
  endtask

  task automatic send_item(input logic [SENS_W-1:0] bits, input logic signed [GYRO_W-1:0] rate);
    while (src_gaps && $urandom_range(99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sensor_bits <= bits;
    in_ch.gyro_rate <= rate;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    fuse_tick(bits, rate);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_errors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned lim, input int unsigned cg, input int unsigned gg,
                            input int unsigned al, input int unsigned kp);
    settle();
    write_reg(CFG_ERROR_LIMIT, lim);
    write_reg(CFG_CORNER_GAIN, cg);
    write_reg(CFG_GYRO_GAIN, gg);
    write_reg(CFG_FUSION_ALPHA, al);
    write_reg(CFG_INTEGRATOR_KEEP, kp);
    cfg_we <= 1'b0;
    lim_cfg = lim & 32'h3FF;
    cgain_cfg = cg & 32'h3F;
    ggain_cfg = gg & 32'hFFFF;
    alpha_cfg = al & 32'h1FFFF;
    keep_cfg = kp & 32'h1FFFF;
  endtask

  function automatic logic [SENS_W-1:0] pick_sensors();
    case ($urandom_range(9))
      0, 1:    return '0;
      2:       return LEFT_CORNER;
      3:       return RIGHT_CORNER;
      default: return SENS_W'($urandom_range(31));
    endcase
  endfunction

  function automatic logic signed [GYRO_W-1:0] pick_rate();
    case ($urandom_range(3))
      0:       return GYRO_W'(int'($urandom_range(400)) - 200);
      default: return GYRO_W'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_q16();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 65536;
      2:       return $urandom_range(131071, 65537);
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic random_config();
    int unsigned lim;
    int unsigned cg;
    int unsigned gg;
    lim = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 1023 : 0) : $urandom_range(1023);
    cg = ($urandom_range(5) == 0) ? 0 : $urandom_range(63, 1);
    gg = ($urandom_range(4) == 0) ? 65535 : $urandom_range(65535);
    set_config(lim, cg, gg, pick_q16(), pick_q16());
  endtask

  task automatic test_reset_values();
    send_item(5'b00000, 16'sd0);
    send_item(5'b00001, 16'sd32767);
    send_item(5'b00010, -16'sd32768);
    send_item(5'b00100, 16'sd0);
    send_item(5'b01000, -16'sd1);
    send_item(5'b10000, 16'sd1);
    send_item(5'b11111, 16'sd100);
    send_item(LEFT_CORNER, 16'sd0);
    send_item(RIGHT_CORNER, 16'sd0);
    send_item(5'b01111, 16'sd0);
    send_item(5'b00000, -16'sd32768);
  endtask

  task automatic test_corner_gain_zero();
    set_config(1023, 0, 2294, 65536, 0);
    send_item(LEFT_CORNER, 16'sd500);
    send_item(RIGHT_CORNER, -16'sd500);
    send_item(5'b00101, 16'sd0);
    send_item(5'b00000, 16'sd0);
  endtask

  task automatic test_limit_extremes();
    set_config(0, 63, 0, 0, 65536);
    send_item(LEFT_CORNER, 16'sd32767);
    send_item(RIGHT_CORNER, -16'sd32768);
    send_item(5'b11111, 16'sd0);
    send_item(5'b00100, 16'sd0);
  endtask

  task automatic test_q16_over_one();
    set_config(1023, 63, 65535, 131071, 131071);
    send_item(LEFT_CORNER, 16'sd1000);
    send_item(RIGHT_CORNER, -16'sd1000);
    send_item(5'b01100, 16'sd32767);
    send_item(5'b00000, 16'sd0);
  endtask

  task automatic test_integrator_saturation();
    set_config(1023, 27, 65535, 65536, 65536);
    repeat (24) send_item(5'b00000, 16'sd32767);
    repeat (48) send_item(5'b00000, -16'sd32768);
    repeat (24) send_item(5'b00000, 16'sd32767);
    send_item(5'b00100, 16'sd0);
  endtask

  task automatic test_random_phases();
    repeat (6) begin
      random_config();
      repeat (95) send_item(pick_sensors(), pick_rate());
    end
  endtask

  task automatic test_no_idle_stretch();
    random_config();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    repeat (200) send_item(pick_sensors(), pick_rate());
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic test_output_backpressure();
    set_config(1023, 27, 2294, 60293, 39322);
    src_gaps = 1'b0;
    -> hold_go;
    repeat (40) send_item(pick_sensors(), pick_rate());
    src_gaps = 1'b1;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sensor_bits = '0;
    in_ch.gyro_rate = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_corner_gain_zero();
    test_limit_extremes();
    test_q16_over_one();
    test_integrator_saturation();
    test_random_phases();
    test_no_idle_stretch();
    test_output_backpressure();
    test_random_phases();

    settle();
    if (expected_errors.size() != 0) begin
      $error("%0d results never arrived", expected_errors.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/lef_pkg.sv
hdl/lef_if.sv
hdl/lef_mul.sv
hdl/line_error_gyro_fusion_core.sv
tb/sv/testbench.sv
